// ===== src/acc_pkg.sv =====
`default_nettype none

package acc_pkg;

    localparam int IN_BITS   = 16;
    localparam int LEFT_BITS = 15;
    localparam int SIZE_BITS = 16;

    typedef struct packed {
        logic [IN_BITS-1:0] source_width;
        logic [IN_BITS-1:0] source_height;
        logic [IN_BITS-1:0] target_width;
        logic [IN_BITS-1:0] target_height;
    } in_word_t;

    typedef struct packed {
        logic [LEFT_BITS-1:0] crop_left;
        logic [LEFT_BITS-1:0] crop_top;
        logic [SIZE_BITS-1:0] crop_width;
        logic [SIZE_BITS-1:0] crop_height;
    } out_word_t;

    typedef enum logic [1:0] {
        MODE_KEEP  = 2'd0,
        MODE_CUT_W = 2'd1,
        MODE_CUT_H = 2'd2,
        MODE_ZERO  = 2'd3
    } mode_t;

endpackage

`default_nettype wire

// ===== src/acc_front.sv =====
`default_nettype none

module acc_front
    import acc_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [WIDTH-1:0]  dn_rem,
    output logic [WIDTH-1:0]  dn_lq,
    output logic [WIDTH-1:0]  dn_div,
    output logic [WIDTH-1:0]  dn_src_w,
    output logic [WIDTH-1:0]  dn_src_h,
    output mode_t             dn_mode
);

    localparam int PW = 2 * WIDTH;

    logic             s1_valid_reg;
    logic             s1_ready;
    logic [WIDTH-1:0] s1_sw_reg;
    logic [WIDTH-1:0] s1_sh_reg;
    logic [WIDTH-1:0] s1_tw_reg;
    logic [WIDTH-1:0] s1_th_reg;
    logic             s1_zero_reg;
    logic [PW-1:0]    s1_wide_reg;
    logic [PW-1:0]    s1_tall_reg;

    logic [WIDTH-1:0] sw_next;
    logic [WIDTH-1:0] sh_next;
    logic [WIDTH-1:0] tw_next;
    logic [WIDTH-1:0] th_next;
    logic             zero_next;
    logic [PW-1:0]    wide_next;
    logic [PW-1:0]    tall_next;

    logic             s2_valid_reg;
    logic [PW-1:0]    s2_dividend_reg;
    logic [WIDTH-1:0] s2_div_reg;
    logic [WIDTH-1:0] s2_sw_reg;
    logic [WIDTH-1:0] s2_sh_reg;
    mode_t            s2_mode_reg;

    mode_t            mode_next;
    logic [PW-1:0]    dividend_next;
    logic [WIDTH-1:0] div_next;

    // input masking and cross products
    assign sw_next   = in_data.source_width[WIDTH-1:0];
    assign sh_next   = in_data.source_height[WIDTH-1:0];
    assign tw_next   = in_data.target_width[WIDTH-1:0];
    assign th_next   = in_data.target_height[WIDTH-1:0];
    assign zero_next = (sw_next == '0) || (sh_next == '0) || (tw_next == '0) || (th_next == '0);
    assign wide_next = PW'(sw_next) * PW'(th_next);
    assign tall_next = PW'(sh_next) * PW'(tw_next);

    assign s1_ready = !s2_valid_reg || dn_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sw_reg   <= sw_next;
            s1_sh_reg   <= sh_next;
            s1_tw_reg   <= tw_next;
            s1_th_reg   <= th_next;
            s1_zero_reg <= zero_next;
            s1_wide_reg <= wide_next;
            s1_tall_reg <= tall_next;
        end
    end

    // pick the axis to cut and set up the division
    always_comb
    begin
        mode_next     = MODE_KEEP;
        dividend_next = '0;
        div_next      = WIDTH'(1);
        if (s1_zero_reg)
        begin
            mode_next = MODE_ZERO;
        end
        else if (s1_wide_reg > s1_tall_reg)
        begin
            mode_next     = MODE_CUT_W;
            dividend_next = s1_tall_reg;
            div_next      = s1_th_reg;
        end
        else if (s1_wide_reg < s1_tall_reg)
        begin
            mode_next     = MODE_CUT_H;
            dividend_next = s1_wide_reg;
            div_next      = s1_tw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_ready)
        begin
            s2_dividend_reg <= dividend_next;
            s2_div_reg      <= div_next;
            s2_sw_reg       <= s1_sw_reg;
            s2_sh_reg       <= s1_sh_reg;
            s2_mode_reg     <= mode_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_rem   = s2_dividend_reg[PW-1:WIDTH];
    assign dn_lq    = s2_dividend_reg[WIDTH-1:0];
    assign dn_div   = s2_div_reg;
    assign dn_src_w = s2_sw_reg;
    assign dn_src_h = s2_sh_reg;
    assign dn_mode  = s2_mode_reg;

endmodule

`default_nettype wire

// ===== src/acc_div_cell.sv =====
`default_nettype none

module acc_div_cell
    import acc_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [WIDTH-1:0]  up_rem,
    input  logic [WIDTH-1:0]  up_lq,
    input  logic [WIDTH-1:0]  up_div,
    input  logic [WIDTH-1:0]  up_src_w,
    input  logic [WIDTH-1:0]  up_src_h,
    input  mode_t             up_mode,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [WIDTH-1:0]  dn_rem,
    output logic [WIDTH-1:0]  dn_lq,
    output logic [WIDTH-1:0]  dn_div,
    output logic [WIDTH-1:0]  dn_src_w,
    output logic [WIDTH-1:0]  dn_src_h,
    output mode_t             dn_mode
);

    logic             valid_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] lq_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH-1:0] src_w_reg;
    logic [WIDTH-1:0] src_h_reg;
    mode_t            mode_reg;

    logic [WIDTH:0]   part;
    logic [WIDTH:0]   diff;
    logic             take;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] lq_next;

    // one restoring step: bring down the next dividend bit, try to subtract
    assign part     = {up_rem, up_lq[WIDTH-1]};
    assign diff     = part - {1'b0, up_div};
    assign take     = !diff[WIDTH];
    assign rem_next = take ? diff[WIDTH-1:0] : part[WIDTH-1:0];
    assign lq_next  = {up_lq[WIDTH-2:0], take};

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rem_reg   <= rem_next;
            lq_reg    <= lq_next;
            div_reg   <= up_div;
            src_w_reg <= up_src_w;
            src_h_reg <= up_src_h;
            mode_reg  <= up_mode;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_lq    = lq_reg;
    assign dn_div   = div_reg;
    assign dn_src_w = src_w_reg;
    assign dn_src_h = src_h_reg;
    assign dn_mode  = mode_reg;

`ifndef ASSERT_OFF
    // partial remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== src/acc_back.sv =====
`default_nettype none

module acc_back
    import acc_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [WIDTH-1:0]  up_quo,
    input  logic [WIDTH-1:0]  up_src_w,
    input  logic [WIDTH-1:0]  up_src_h,
    input  mode_t             up_mode,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data
);

    logic                 valid_reg;
    out_word_t            data_reg;
    out_word_t            data_next;

    logic [SIZE_BITS-1:0] sw;
    logic [SIZE_BITS-1:0] sh;
    logic [SIZE_BITS-1:0] quo;
    logic                 quo_bad_w;
    logic                 quo_bad_h;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    logic [SIZE_BITS-1:0] x;
    logic [SIZE_BITS-1:0] y;

    assign sw        = SIZE_BITS'(up_src_w);
    assign sh        = SIZE_BITS'(up_src_h);
    assign quo       = SIZE_BITS'(up_quo);
    assign quo_bad_w = (quo == '0) || (quo > sw);
    assign quo_bad_h = (quo == '0) || (quo > sh);

    always_comb
    begin
        w = sw;
        h = sh;
        x = '0;
        y = '0;
        case (up_mode)
            MODE_ZERO:
            begin
                w = '0;
                h = '0;
            end
            MODE_CUT_W:
            begin
                w = quo_bad_w ? sw : quo;
                x = (sw - w) >> 1;
            end
            MODE_CUT_H:
            begin
                h = quo_bad_h ? sh : quo;
                y = (sh - h) >> 1;
            end
            default:
            begin
                w = sw;
                h = sh;
            end
        endcase
        data_next.crop_left   = x[LEFT_BITS-1:0];
        data_next.crop_top    = y[LEFT_BITS-1:0];
        data_next.crop_width  = w;
        data_next.crop_height = h;
    end

    assign up_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    a_empty_both_axes: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.crop_width == '0) == (data_reg.crop_height == '0)))
        else $error("crop empty on one axis only");

    a_one_axis_cut: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg.crop_left == '0) || (data_reg.crop_top == '0)))
        else $error("crop offset on both axes");

    a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (data_reg.crop_width == '0))
            |-> ((data_reg.crop_left == '0) && (data_reg.crop_top == '0)))
        else $error("empty crop not at origin");
`endif

endmodule

`default_nettype wire

// ===== src/aspect_center_crop_core.sv =====
// throughput: one word per cycle while out_ready stays high,
// every stage passes its word on in the cycle it is freed
// two front stages (cross products, axis select), one cell per bit, one output register
// reset: rst_n asynchronous active low, clears all valid flags, pipeline comes up empty
`default_nettype none

module aspect_center_crop_core
    import acc_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int DW = (DIM_BITS < IN_BITS) ? DIM_BITS : IN_BITS;

    logic          cv   [0:DW];
    logic          cr   [0:DW];
    logic [DW-1:0] crem [0:DW];
    logic [DW-1:0] clq  [0:DW];
    logic [DW-1:0] cdiv [0:DW];
    logic [DW-1:0] csw  [0:DW];
    logic [DW-1:0] csh  [0:DW];
    mode_t         cmode[0:DW];

    acc_front #(
        .WIDTH (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .dn_valid (cv[0]),
        .dn_ready (cr[0]),
        .dn_rem   (crem[0]),
        .dn_lq    (clq[0]),
        .dn_div   (cdiv[0]),
        .dn_src_w (csw[0]),
        .dn_src_h (csh[0]),
        .dn_mode  (cmode[0])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        acc_div_cell #(
            .WIDTH (DW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cv[i]),
            .up_ready (cr[i]),
            .up_rem   (crem[i]),
            .up_lq    (clq[i]),
            .up_div   (cdiv[i]),
            .up_src_w (csw[i]),
            .up_src_h (csh[i]),
            .up_mode  (cmode[i]),
            .dn_valid (cv[i+1]),
            .dn_ready (cr[i+1]),
            .dn_rem   (crem[i+1]),
            .dn_lq    (clq[i+1]),
            .dn_div   (cdiv[i+1]),
            .dn_src_w (csw[i+1]),
            .dn_src_h (csh[i+1]),
            .dn_mode  (cmode[i+1])
        );
    end

    acc_back #(
        .WIDTH (DW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (cv[DW]),
        .up_ready  (cr[DW]),
        .up_quo    (clq[DW]),
        .up_src_w  (csw[DW]),
        .up_src_h  (csh[DW]),
        .up_mode   (cmode[DW]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // final remainder and divisor are not needed past the last cell
    logic unused_tail;
    assign unused_tail = ^{crem[DW], cdiv[DW]};

endmodule

`default_nettype wire
